/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL. Each expects clk in scope; TDPS_ASSERT also expects arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define TDPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define TDPS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/tdps_pkg.sv */
package tdps_pkg;

	localparam int POS_WIDTH      = 24;
	localparam int ERR_WIDTH      = POS_WIDTH + 1;
	localparam int MEAN_WIDTH     = 24;
	localparam int WIDE_WIDTH     = (ERR_WIDTH > MEAN_WIDTH) ? ERR_WIDTH : MEAN_WIDTH;
	localparam int GAIN_WIDTH     = 10;
	localparam int GAIN_FRAC      = 8;
	localparam int SLEW_WIDTH     = 7;
	localparam int LIMIT_WIDTH    = 7;
	localparam int BAND_WIDTH     = 8;
	localparam int COUNT_WIDTH    = 8;
	localparam int DRIVE_WIDTH    = 8;
	localparam int CFG_IDX_WIDTH  = 3;
	localparam int CFG_DATA_WIDTH = 10;

	typedef logic signed [POS_WIDTH-1:0]   pos_t;
	typedef logic signed [ERR_WIDTH-1:0]   err_t;
	typedef logic        [ERR_WIDTH-1:0]   mag_t;
	typedef logic        [MEAN_WIDTH-1:0]  mean_t;
	typedef logic        [GAIN_WIDTH-1:0]  gain_t;
	typedef logic        [SLEW_WIDTH-1:0]  slew_t;
	typedef logic        [LIMIT_WIDTH-1:0] limit_t;
	typedef logic        [BAND_WIDTH-1:0]  band_t;
	typedef logic        [COUNT_WIDTH-1:0] count_t;
	typedef logic signed [DRIVE_WIDTH-1:0] drive_t;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		CFG_GAIN_STRAIGHT = 3'd0,
		CFG_GAIN_TURN     = 3'd1,
		CFG_SLEW_STRAIGHT = 3'd2,
		CFG_SLEW_TURN     = 3'd3,
		CFG_SETTLE_BAND   = 3'd4,
		CFG_STALL_LIMIT   = 3'd5
	} cfg_idx_t;

	localparam logic MODE_START  = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	localparam gain_t  GAIN_STRAIGHT_RST = 10'd38;
	localparam gain_t  GAIN_TURN_RST     = 10'd179;
	localparam slew_t  SLEW_STRAIGHT_RST = 7'd5;
	localparam slew_t  SLEW_TURN_RST     = 7'd4;
	localparam band_t  SETTLE_BAND_RST   = 8'd5;
	localparam count_t STALL_LIMIT_RST   = 8'd10;

	localparam mean_t  MEAN_MAX  = '1;
	localparam count_t COUNT_MAX = '1;

endpackage

/* rtl/core/tdps_side.sv */
module tdps_side (
	input  tdps_pkg::err_t   err,
	input  tdps_pkg::gain_t  gain,
	input  tdps_pkg::limit_t cap,
	output tdps_pkg::mag_t   mag,
	output tdps_pkg::drive_t drive
);

	localparam int PROD_WIDTH = tdps_pkg::ERR_WIDTH + tdps_pkg::GAIN_WIDTH;

	logic                  neg;
	logic [PROD_WIDTH-1:0] prod;
	logic [PROD_WIDTH-1:0] scaled;
	tdps_pkg::limit_t      clamped;

	assign neg  = err[tdps_pkg::ERR_WIDTH-1];
	assign mag  = neg ? tdps_pkg::mag_t'(-err) : tdps_pkg::mag_t'(err);
	assign prod = PROD_WIDTH'(mag) * PROD_WIDTH'(gain);
	// truncate toward zero: scale the magnitude, sign goes back on afterwards
	assign scaled = prod >> tdps_pkg::GAIN_FRAC;

	always_comb begin
		if (scaled > PROD_WIDTH'(cap)) begin
			clamped = cap;
		end else begin
			clamped = tdps_pkg::limit_t'(scaled);
		end
	end

	assign drive = neg ? -tdps_pkg::drive_t'({1'b0, clamped})
	                   : tdps_pkg::drive_t'({1'b0, clamped});

endmodule

/* rtl/core/tank_drive_p_slew_settle_top.sv */
// Two-sided proportional drive controller with a ramping drive cap.
// Input channel (in_valid / in_stall): one word per item. mode = 0 starts a move
// and loads target_left, target_right and drive_limit; mode = 1 is a sample
// carrying pos_left and pos_right. Every input word yields exactly one output
// word on the output channel (out_valid / out_stall): drive_left, drive_right,
// done_res and mean_error.
// Configuration channel (cfg_valid / cfg_ready): cfg_index selects gain_straight,
// gain_turn, slew_straight, slew_turn, settle_band or stall_limit; cfg_ready is
// always high. Write only while no item is in flight.
// Path: a word accepted is captured in the input register and moves on to the
// output register once the update step takes it.
// Throughput: one word per cycle while unstalled, set by the single update step
// between the input and output registers, which also updates the move state.
// Stall: while out_stall holds a valid output word, the update step waits and
// in_stall rises as soon as the input register is full; nothing is dropped.
// Reset: both registers empty, the block idle (samples return done with zero
// drive), configuration back to its default values.
`include "assert_macros.svh"

module tank_drive_p_slew_settle_top (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tdps_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
	input  logic [tdps_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,

	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  mode,
	input  tdps_pkg::pos_t                        target_left,
	input  tdps_pkg::pos_t                        target_right,
	input  tdps_pkg::limit_t                      drive_limit,
	input  tdps_pkg::pos_t                        pos_left,
	input  tdps_pkg::pos_t                        pos_right,

	output logic                                  out_valid,
	input  logic                                  out_stall,
	output tdps_pkg::drive_t                      drive_left,
	output tdps_pkg::drive_t                      drive_right,
	output logic                                  done_res,
	output tdps_pkg::mean_t                       mean_error
);

	// configuration
	tdps_pkg::gain_t  gain_straight_q, gain_turn_q;
	tdps_pkg::slew_t  slew_straight_q, slew_turn_q;
	tdps_pkg::band_t  settle_band_q;
	tdps_pkg::count_t stall_limit_q;

	// move state
	tdps_pkg::pos_t   goal_left_q, goal_right_q;
	tdps_pkg::limit_t move_limit_q, ramp_cap_q;
	tdps_pkg::mean_t  previous_error_q;
	tdps_pkg::count_t stall_count_q;
	logic             moving_q;

	// input register
	logic             valid_s1;
	logic             mode_s1;
	tdps_pkg::pos_t   target_left_s1, target_right_s1, pos_left_s1, pos_right_s1;
	tdps_pkg::limit_t drive_limit_s1;

	// output register
	logic             out_valid_q;
	tdps_pkg::drive_t drive_left_q, drive_right_q;
	logic             done_q;
	tdps_pkg::mean_t  mean_q;

	logic out_free, take, accept;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign take      = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign accept    = in_valid && !in_stall;

	// update step
	tdps_pkg::err_t   err_left, err_right;
	tdps_pkg::mag_t   mag_left, mag_right;
	tdps_pkg::drive_t side_left, side_right;
	logic [tdps_pkg::ERR_WIDTH:0]      mag_sum;
	logic [tdps_pkg::WIDE_WIDTH-1:0]   half_w;
	tdps_pkg::mean_t  mean_cur;
	logic             same_sign;
	tdps_pkg::gain_t  gain_sel;
	tdps_pkg::slew_t  slew_sel;
	logic [tdps_pkg::LIMIT_WIDTH:0]    cap_sum;
	tdps_pkg::limit_t cap_next;
	tdps_pkg::count_t count_next;
	logic             finished;

	assign err_left  = tdps_pkg::err_t'(goal_left_q) - tdps_pkg::err_t'(pos_left_s1);
	assign err_right = tdps_pkg::err_t'(goal_right_q) - tdps_pkg::err_t'(pos_right_s1);

	// zero counts as positive, so the sign bit alone decides
	assign same_sign = err_left[tdps_pkg::ERR_WIDTH-1] == err_right[tdps_pkg::ERR_WIDTH-1];
	assign gain_sel  = same_sign ? gain_straight_q : gain_turn_q;
	assign slew_sel  = same_sign ? slew_straight_q : slew_turn_q;

	tdps_side u_side_left (
		.err   (err_left),
		.gain  (gain_sel),
		.cap   (cap_next),
		.mag   (mag_left),
		.drive (side_left)
	);

	tdps_side u_side_right (
		.err   (err_right),
		.gain  (gain_sel),
		.cap   (cap_next),
		.mag   (mag_right),
		.drive (side_right)
	);

	assign mag_sum = {1'b0, mag_left} + {1'b0, mag_right};
	assign half_w  = tdps_pkg::WIDE_WIDTH'(mag_sum[tdps_pkg::ERR_WIDTH:1]);

	always_comb begin
		if (half_w > tdps_pkg::WIDE_WIDTH'(tdps_pkg::MEAN_MAX)) begin
			mean_cur = tdps_pkg::MEAN_MAX;
		end else begin
			mean_cur = tdps_pkg::mean_t'(half_w);
		end
	end

	assign cap_sum  = {1'b0, ramp_cap_q} + {1'b0, slew_sel};
	assign cap_next = (cap_sum > {1'b0, move_limit_q}) ? move_limit_q
	                                                   : tdps_pkg::limit_t'(cap_sum);

	always_comb begin
		if (previous_error_q == mean_cur) begin
			count_next = (stall_count_q == tdps_pkg::COUNT_MAX) ? stall_count_q
			                                                    : stall_count_q + 1'b1;
		end else begin
			count_next = '0;
		end
	end

	assign finished = (previous_error_q < tdps_pkg::mean_t'(settle_band_q) &&
	                   mean_cur < tdps_pkg::mean_t'(settle_band_q)) ||
	                  (count_next >= stall_limit_q);

	// control, configuration and move state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_straight_q  <= tdps_pkg::GAIN_STRAIGHT_RST;
			gain_turn_q      <= tdps_pkg::GAIN_TURN_RST;
			slew_straight_q  <= tdps_pkg::SLEW_STRAIGHT_RST;
			slew_turn_q      <= tdps_pkg::SLEW_TURN_RST;
			settle_band_q    <= tdps_pkg::SETTLE_BAND_RST;
			stall_limit_q    <= tdps_pkg::STALL_LIMIT_RST;
			goal_left_q      <= '0;
			goal_right_q     <= '0;
			move_limit_q     <= '0;
			ramp_cap_q       <= '0;
			previous_error_q <= '0;
			stall_count_q    <= '0;
			moving_q         <= 1'b0;
			valid_s1         <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (tdps_pkg::cfg_idx_t'(cfg_index))
					tdps_pkg::CFG_GAIN_STRAIGHT: gain_straight_q <= cfg_data;
					tdps_pkg::CFG_GAIN_TURN:     gain_turn_q     <= cfg_data;
					tdps_pkg::CFG_SLEW_STRAIGHT: slew_straight_q <= tdps_pkg::slew_t'(cfg_data);
					tdps_pkg::CFG_SLEW_TURN:     slew_turn_q     <= tdps_pkg::slew_t'(cfg_data);
					tdps_pkg::CFG_SETTLE_BAND:   settle_band_q   <= tdps_pkg::band_t'(cfg_data);
					tdps_pkg::CFG_STALL_LIMIT:   stall_limit_q   <= tdps_pkg::count_t'(cfg_data);
					default: ;
				endcase
			end

			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end

			if (take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (take) begin
				if (mode_s1 == tdps_pkg::MODE_START) begin
					goal_left_q      <= target_left_s1;
					goal_right_q     <= target_right_s1;
					move_limit_q     <= drive_limit_s1;
					ramp_cap_q       <= '0;
					previous_error_q <= '0;
					stall_count_q    <= '0;
					moving_q         <= 1'b1;
				end else if (moving_q) begin
					ramp_cap_q    <= cap_next;
					stall_count_q <= count_next;
					if (finished) begin
						moving_q <= 1'b0;
					end else begin
						previous_error_q <= mean_cur;
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1         <= mode;
			target_left_s1  <= target_left;
			target_right_s1 <= target_right;
			drive_limit_s1  <= drive_limit;
			pos_left_s1     <= pos_left;
			pos_right_s1    <= pos_right;
		end
		if (take) begin
			if (mode_s1 == tdps_pkg::MODE_START) begin
				drive_left_q  <= '0;
				drive_right_q <= '0;
				done_q        <= 1'b0;
				mean_q        <= '0;
			end else if (!moving_q) begin
				drive_left_q  <= '0;
				drive_right_q <= '0;
				done_q        <= 1'b1;
				mean_q        <= '0;
			end else if (finished) begin
				drive_left_q  <= '0;
				drive_right_q <= '0;
				done_q        <= 1'b1;
				mean_q        <= mean_cur;
			end else begin
				drive_left_q  <= side_left;
				drive_right_q <= side_right;
				done_q        <= 1'b0;
				mean_q        <= mean_cur;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_left  = drive_left_q;
	assign drive_right = drive_right_q;
	assign done_res    = done_q;
	assign mean_error  = mean_q;

	`TDPS_ASSERT(a_done_zero_drive, out_valid_q && done_q |-> drive_left_q == '0 && drive_right_q == '0, "done word carries nonzero drive")
	`TDPS_ASSERT(a_cap_in_limit, ramp_cap_q <= move_limit_q, "ramp cap above move limit")
	`TDPS_ASSERT(a_hold_stalled, out_valid_q && out_stall |=> out_valid_q, "stalled output word dropped")
	`TDPS_ASSERT(a_drive_in_cap, out_valid_q && !done_q |-> drive_left_q <= tdps_pkg::drive_t'({1'b0, ramp_cap_q}) && drive_left_q >= -tdps_pkg::drive_t'({1'b0, ramp_cap_q}), "left drive exceeds cap")

endmodule

/* dv/tb_tank_drive_p_slew_settle_top.sv */
`timescale 1ns / 1ps

module tb_tank_drive_p_slew_settle_top;
	import tdps_pkg::*;

	localparam int   QUIET_LIMIT = 4000;
	localparam pos_t P_MAX       = 24'sh7FFFFF;
	localparam pos_t P_MIN       = 24'sh800000;

	typedef struct packed {
		logic   mode;
		pos_t   tgt_l;
		pos_t   tgt_r;
		limit_t lim;
		pos_t   pos_l;
		pos_t   pos_r;
	} drive_word_t;

	typedef struct packed {
		drive_t drv_l;
		drive_t drv_r;
		logic   done;
		mean_t  mean;
	} drive_cmd_t;

	typedef struct packed {
		drive_word_t w;
		logic        pin;
		drive_cmd_t  cmd;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	drive_word_t in_word = '0;
	logic        pin_now = 1'b0;
	drive_cmd_t  pin_cmd = '0;

	logic       out_valid;
	logic       out_stall = 1'b0;
	drive_t     drive_left;
	drive_t     drive_right;
	logic       done_res;
	mean_t      mean_error;

	logic                      mode;
	pos_t                      target_left;
	pos_t                      target_right;
	limit_t                    drive_limit;
	pos_t                      pos_left;
	pos_t                      pos_right;

	assign mode         = in_word.mode;
	assign target_left  = in_word.tgt_l;
	assign target_right = in_word.tgt_r;
	assign drive_limit  = in_word.lim;
	assign pos_left     = in_word.pos_l;
	assign pos_right    = in_word.pos_r;

	tank_drive_p_slew_settle_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.target_left  (target_left),
		.target_right (target_right),
		.drive_limit  (drive_limit),
		.pos_left     (pos_left),
		.pos_right    (pos_right),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.drive_left   (drive_left),
		.drive_right  (drive_right),
		.done_res     (done_res),
		.mean_error   (mean_error)
	);

	always #4 clk = ~clk;

	// controller copy: configuration
	gain_t  gain_fwd  = GAIN_STRAIGHT_RST;
	gain_t  gain_spin = GAIN_TURN_RST;
	slew_t  slew_fwd  = SLEW_STRAIGHT_RST;
	slew_t  slew_spin = SLEW_TURN_RST;
	band_t  band      = SETTLE_BAND_RST;
	count_t stall_max = STALL_LIMIT_RST;

	// controller copy: move state
	pos_t   goal_l    = '0;
	pos_t   goal_r    = '0;
	limit_t move_lim  = '0;
	limit_t ramp      = '0;
	mean_t  prev_err  = '0;
	count_t stall_cnt = '0;
	logic   in_move   = 1'b0;

	drive_cmd_t pending_cmds[$];
	bit         mismatch = 1'b0;
	int         send_pct = 0;
	int         recv_pct = 0;
	int         quiet = 0;

	plan_row_t plan [25] = '{
		'{'{MODE_SAMPLE, 0, 0, 7'd0, 5, -5}, 1'b1, '{0, 0, 1'b1, 0}},
		'{'{MODE_SAMPLE, 0, 0, 7'd0, P_MAX, P_MIN}, 1'b1, '{0, 0, 1'b1, 0}},
		'{'{MODE_START, P_MAX, P_MIN, 7'd127, 0, 0}, 1'b1, '{0, 0, 1'b0, 0}},
		'{'{MODE_SAMPLE, 0, 0, 7'd0, P_MIN, P_MAX}, 1'b0, '0},
		'{'{MODE_SAMPLE, 0, 0, 7'd0, P_MIN, P_MAX}, 1'b0, '0},
		'{'{MODE_SAMPLE, 0, 0, 7'd0, 0, 0}, 1'b0, '0},
		'{'{MODE_START, P_MIN, P_MIN, 7'd127, 0, 0}, 1'b1, '{0, 0, 1'b0, 0}},
		'{'{MODE_SAMPLE, 0, 0, 7'd0, P_MAX, P_MAX}, 1'b0, '0},
		'{'{MODE_START, 0, 0, 7'd0, 0, 0}, 1'b1, '{0, 0, 1'b0, 0}},
		// zero error on the first sample settles at once
		'{'{MODE_SAMPLE, 0, 0, 7'd0, 0, 0}, 1'b1, '{0, 0, 1'b1, 0}},
		'{'{MODE_SAMPLE, 0, 0, 7'd0, 0, 0}, 1'b1, '{0, 0, 1'b1, 0}},
		'{'{MODE_START, 1000, -1000, 7'd3, 0, 0}, 1'b1, '{0, 0, 1'b0, 0}},
		'{'{MODE_SAMPLE, 0, 0, 7'd0, 0, 0}, 1'b1, '{3, -3, 1'b0, 1000}},
		'{'{MODE_SAMPLE, 0, 0, 7'd0, 0, 0}, 1'b0, '0},
		'{'{MODE_SAMPLE, 0, 0, 7'd0, 998, -998}, 1'b0, '0},
		'{'{MODE_SAMPLE, 0, 0, 7'd0, 997, -997}, 1'b1, '{0, 0, 1'b1, 3}},
		'{'{MODE_START, -100, -100, 7'd127, 0, 0}, 1'b1, '{0, 0, 1'b0, 0}},
		'{'{MODE_SAMPLE, 0, 0, 7'd0, 0, 0}, 1'b0, '0},
		'{'{MODE_SAMPLE, 0, 0, 7'd0, 0, 0}, 1'b0, '0},
		'{'{MODE_SAMPLE, 0, 0, 7'd0, 0, 0}, 1'b0, '0},
		'{'{MODE_SAMPLE, 0, 0, 7'd0, -100, -100}, 1'b0, '0},
		'{'{MODE_SAMPLE, 0, 0, 7'd0, -100, -100}, 1'b1, '{0, 0, 1'b1, 0}},
		'{'{MODE_START, 50, -50, 7'd127, 0, 0}, 1'b1, '{0, 0, 1'b0, 0}},
		// zero error on one side counts as positive
		'{'{MODE_SAMPLE, 0, 0, 7'd0, 50, -40}, 1'b0, '0},
		'{'{MODE_SAMPLE, 0, 0, 7'd0, 40, -50}, 1'b0, '0}
	};

	function automatic drive_t side_cmd(input longint err, input longint gain,
			input longint cap);
		longint mag;
		mag = ((err < 0 ? -err : err) * gain) >>> GAIN_FRAC;
		if (mag > cap)
			mag = cap;
		return drive_t'(err < 0 ? -mag : mag);
	endfunction

	function automatic drive_cmd_t next_drive_cmd(input drive_word_t w);
		drive_cmd_t c;
		longint     el, er, m, capw, gain;
		logic       same, done;
		c = '0;
		if (w.mode == MODE_START) begin
			goal_l    = w.tgt_l;
			goal_r    = w.tgt_r;
			move_lim  = w.lim;
			ramp      = '0;
			prev_err  = '0;
			stall_cnt = '0;
			in_move   = 1'b1;
			return c;
		end
		if (!in_move) begin
			c.done = 1'b1;
			return c;
		end
		el = longint'(goal_l) - longint'(w.pos_l);
		er = longint'(goal_r) - longint'(w.pos_r);
		m = ((el < 0 ? -el : el) + (er < 0 ? -er : er)) >>> 1;
		if (m > longint'(MEAN_MAX))
			m = longint'(MEAN_MAX);
		same = (el < 0) == (er < 0);
		gain = same ? longint'(gain_fwd) : longint'(gain_spin);
		capw = longint'(ramp) + (same ? longint'(slew_fwd) : longint'(slew_spin));
		if (capw > longint'(move_lim))
			capw = longint'(move_lim);
		ramp = limit_t'(capw);
		if (longint'(prev_err) == m) begin
			if (stall_cnt != COUNT_MAX)
				stall_cnt = stall_cnt + 1'b1;
		end else begin
			stall_cnt = '0;
		end
		done = (longint'(prev_err) < longint'(band) && m < longint'(band)) ||
			stall_cnt >= stall_max;
		c.mean = mean_t'(m);
		if (done) begin
			in_move = 1'b0;
			c.done  = 1'b1;
		end else begin
			prev_err = mean_t'(m);
			c.drv_l  = side_cmd(el, gain, capw);
			c.drv_r  = side_cmd(er, gain, capw);
		end
		return c;
	endfunction

	function automatic void apply_cfg(input cfg_idx_t idx, input logic [CFG_DATA_WIDTH-1:0] val);
		case (idx)
			CFG_GAIN_STRAIGHT: gain_fwd  = val[GAIN_WIDTH-1:0];
			CFG_GAIN_TURN:     gain_spin = val[GAIN_WIDTH-1:0];
			CFG_SLEW_STRAIGHT: slew_fwd  = val[SLEW_WIDTH-1:0];
			CFG_SLEW_TURN:     slew_spin = val[SLEW_WIDTH-1:0];
			CFG_SETTLE_BAND:   band      = val[BAND_WIDTH-1:0];
			CFG_STALL_LIMIT:   stall_max = val[COUNT_WIDTH-1:0];
			default: ;
		endcase
	endfunction

	always @(negedge clk)
		out_stall <= arst_n && ($urandom_range(99) < recv_pct);

	always @(posedge clk) begin : monitor
		drive_cmd_t want, got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{drive_left, drive_right, done_res, mean_error};
				if (pending_cmds.size() == 0) begin
					$display("%0t: unexpected word, got %0d %0d %0b %0d", $time,
						got.drv_l, got.drv_r, got.done, got.mean);
					mismatch = 1'b1;
				end else begin
					want = pending_cmds.pop_front();
					if (got.drv_l !== want.drv_l) begin
						$display("%0t: drive_left expected %0d got %0d", $time,
							want.drv_l, got.drv_l);
						mismatch = 1'b1;
					end
					if (got.drv_r !== want.drv_r) begin
						$display("%0t: drive_right expected %0d got %0d", $time,
							want.drv_r, got.drv_r);
						mismatch = 1'b1;
					end
					if (got.done !== want.done) begin
						$display("%0t: done_res expected %0b got %0b", $time,
							want.done, got.done);
						mismatch = 1'b1;
					end
					if (got.mean !== want.mean) begin
						$display("%0t: mean_error expected %0d got %0d", $time,
							want.mean, got.mean);
						mismatch = 1'b1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				want = next_drive_cmd(in_word);
				if (pin_now)
					want = pin_cmd;
				pending_cmds.push_back(want);
			end
			if (cfg_valid && cfg_ready)
				apply_cfg(cfg_idx_t'(cfg_index), cfg_data);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("[tank_drive_p_slew_settle_top] ERROR");
				$finish;
			end
		end
	end

	task automatic send_word(input drive_word_t w, input logic pin, input drive_cmd_t c);
		@(negedge clk);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		pin_now  <= pin;
		pin_cmd  <= c;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// drop valid and hold until every pending word is back
	task automatic settle_out();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_word(input cfg_idx_t idx, input logic [CFG_DATA_WIDTH-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	task automatic load_cfg(input int gs, input int gt, input int ss, input int st,
			input int bd, input int sl);
		cfg_word(CFG_GAIN_STRAIGHT, CFG_DATA_WIDTH'(gs));
		cfg_word(CFG_GAIN_TURN, CFG_DATA_WIDTH'(gt));
		cfg_word(CFG_SLEW_STRAIGHT, CFG_DATA_WIDTH'(ss));
		cfg_word(CFG_SLEW_TURN, CFG_DATA_WIDTH'(st));
		cfg_word(CFG_SETTLE_BAND, CFG_DATA_WIDTH'(bd));
		cfg_word(CFG_STALL_LIMIT, CFG_DATA_WIDTH'(sl));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic longint pick_err(input pos_t goal);
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return longint'(int'($urandom_range(0, 300)) - 150);
		if (r < 85)
			return longint'(int'($urandom_range(0, 200000)) - 100000);
		return longint'(goal) - longint'(pos_t'($urandom));
	endfunction

	function automatic longint shrink_err(input longint e);
		longint n;
		n = e;
		if ($urandom_range(3) != 0)
			n = n * longint'($urandom_range(0, 9)) / 10;
		if ($urandom_range(7) == 0)
			n = -n;
		return n;
	endfunction

	// mostly well-formed moves converging on target, with some noise words
	task automatic run_moves(input int n);
		drive_word_t w;
		int          sent, steps;
		logic        hold;
		longint      el, er;
		sent = 0;
		while (sent < n) begin
			w = '0;
			if ($urandom_range(9) == 0) begin
				w.mode  = logic'($urandom_range(1));
				w.tgt_l = pos_t'($urandom);
				w.tgt_r = pos_t'($urandom);
				w.lim   = limit_t'($urandom);
				w.pos_l = pos_t'($urandom);
				w.pos_r = pos_t'($urandom);
				send_word(w, 1'b0, '0);
				sent++;
			end else begin
				w.mode = MODE_START;
				if ($urandom_range(3) == 0) begin
					w.tgt_l = pos_t'($urandom);
					w.tgt_r = pos_t'($urandom);
				end else begin
					w.tgt_l = pos_t'(int'($urandom_range(0, 20000)) - 10000);
					w.tgt_r = pos_t'(int'($urandom_range(0, 20000)) - 10000);
				end
				w.lim = limit_t'($urandom_range(127));
				send_word(w, 1'b0, '0);
				sent++;
				el    = pick_err(w.tgt_l);
				er    = pick_err(w.tgt_r);
				steps = $urandom_range(1, 24);
				hold  = ($urandom_range(4) == 0);
				w.mode = MODE_SAMPLE;
				repeat (steps) begin
					w.pos_l = pos_t'(longint'(w.tgt_l) - el);
					w.pos_r = pos_t'(longint'(w.tgt_r) - er);
					send_word(w, 1'b0, '0);
					sent++;
					if (!hold) begin
						el = shrink_err(el);
						er = shrink_err(er);
					end
				end
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_pct = 31;
		recv_pct = 74;
		foreach (plan[i])
			send_word(plan[i].w, plan[i].pin, plan[i].cmd);

		for (int blk = 0; blk < 6; blk++) begin
			settle_out();
			if (blk == 2) begin
				send_pct = 74;
				recv_pct = 31;
			end else if (blk == 4) begin
				send_pct = 0;
				recv_pct = 0;
			end
			case (blk)
				0: load_cfg(GAIN_STRAIGHT_RST, GAIN_TURN_RST, SLEW_STRAIGHT_RST,
					SLEW_TURN_RST, SETTLE_BAND_RST, STALL_LIMIT_RST);
				1: load_cfg($urandom_range(1023), $urandom_range(1023), $urandom_range(127),
					$urandom_range(127), $urandom_range(255), $urandom_range(1, 40));
				2: load_cfg(1023, 1023, 127, 127, 255, 255);
				3: load_cfg(0, 0, 0, 0, 0, 1);
				// zero stall limit ends every move on its first sample
				4: load_cfg($urandom_range(1023), $urandom_range(1023), $urandom_range(127),
					$urandom_range(127), $urandom_range(255), 0);
				default: load_cfg($urandom_range(64, 512), $urandom_range(64, 512),
					$urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(1, 40),
					$urandom_range(1, 20));
			endcase
			run_moves(100);
			if (blk == 0)
				settle_out();
			run_moves(100);
		end

		settle_out();
		repeat (8) @(posedge clk);
		if (!mismatch)
			$display("[tank_drive_p_slew_settle_top] OK");
		else
			$display("[tank_drive_p_slew_settle_top] ERROR");
		$finish;
	end

endmodule
